@@ rtl/core/ntm_pkg.sv @@
`timescale 1ns / 1ps
// Package with the shared constants of the normalized triangular membership block.
package ntm_pkg;

    localparam int DEF_MAX_RULES   = 16;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam int DEGREE_W   = 16;
    localparam int RULE_NUM_W = 4;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

endpackage

@@ rtl/core/ntm_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module ntm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/ntm_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider giving floor(num * 2^15 / den) for num not above den.
module ntm_div
    import ntm_pkg::*;
#(
    parameter int DW = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DW-1:0]       num,
    input  logic [DW-1:0]       den,
    output logic                done,
    output logic [DEGREE_W-1:0] quot
);

    localparam int CW = $clog2(DEGREE_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(DEGREE_W - 1);

    logic                busy_reg, busy_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       den_reg, den_next;
    logic [DEGREE_W-1:0] q_reg, q_next;
    logic [DW:0]         trial;
    logic [DW:0]         diff;
    logic                ge;

    always_comb
    begin
        trial = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            q_next   = {q_reg[DEGREE_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign done = busy_reg && (cnt_reg == LAST_STEP);
    assign quot = {q_reg[DEGREE_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            q_reg    <= q_next;
        end
    end

endmodule

@@ rtl/core/normalized_triangular_membership.sv @@
`timescale 1ns / 1ps
// Top level of the normalized triangular fuzzy membership block.
//
//  Channel  Handshake           Beat contents
//  in       in_valid/in_ready   func, rule_index, left_foot, peak_point, right_foot,
//                               sample_value
//  out      out_valid/out_ready rule_number, weight, last
//  cfg      cfg_we              cfg_wdata (rules_in_use)
//
// Evaluating N rules in use: each rule needs a rule table read and, when the sample
// lies inside its triangle, 16 divider steps for its degree; then each needs a degree
// store read and, unless the degree sum is zero, 16 divider steps for its weight.
// One shared divider does both, one quotient bit per step. Reset is asynchronous and
// leaves the tables undefined; a stalled output beat holds the block until taken.
module normalized_triangular_membership
    import ntm_pkg::*;
#(
    parameter int MAX_RULES   = DEF_MAX_RULES,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [3:0]                    rule_index,
    input  logic signed [VALUE_WIDTH-1:0] left_foot,
    input  logic signed [VALUE_WIDTH-1:0] peak_point,
    input  logic signed [VALUE_WIDTH-1:0] right_foot,
    input  logic signed [VALUE_WIDTH-1:0] sample_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [RULE_NUM_W-1:0]         rule_number,
    output logic [DEGREE_W-1:0]           weight,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [CFG_W-1:0]              cfg_wdata
);

    localparam int VW    = VALUE_WIDTH;
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int SUM_W = DEGREE_W + ((MAX_RULES > 1) ? $clog2(MAX_RULES) : 0);
    localparam int DW    = (VW > SUM_W) ? VW : SUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RULE_RD,
        S_RULE_SETUP,
        S_RULE_DIV,
        S_NORM_RD,
        S_NORM_SETUP,
        S_NORM_DIV,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       last_idx_reg, last_idx_next;
    logic signed [VW-1:0]   sample_reg, sample_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CFG_W-1:0]       rules_in_use_reg, rules_in_use_next;
    logic                   out_valid_reg, out_valid_next;
    logic [RULE_NUM_W-1:0]  rule_number_reg, rule_number_next;
    logic [DEGREE_W-1:0]    weight_reg, weight_next;
    logic                   last_reg, last_next;

    logic                   in_fire;
    logic [31:0]            cfg_count;
    logic [31:0]            rule_count;

    logic                   rt_we;
    logic [IDX_W-1:0]       rt_waddr;
    logic [3*VW-1:0]        rt_wdata;
    logic [3*VW-1:0]        rt_rdata;
    logic                   dg_we;
    logic [DEGREE_W-1:0]    dg_wdata;
    logic [DEGREE_W-1:0]    dg_rdata;

    logic signed [VW-1:0]   rule_left, rule_peak, rule_right;
    logic signed [VW:0]     d_xa, d_ba, d_cx, d_cb;
    logic                   rise, fall;
    logic [DW-1:0]          mem_num, mem_den;

    logic                   div_start;
    logic [DW-1:0]          div_num, div_den;
    logic                   div_done;
    logic [DEGREE_W-1:0]    div_quot;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign rt_we    = in_fire && (func == FUNC_LOAD) && (32'(rule_index) < 32'(MAX_RULES));
    assign rt_waddr = IDX_W'(rule_index);
    assign rt_wdata = {left_foot, peak_point, right_foot};

    assign rule_left  = rt_rdata[3*VW-1:2*VW];
    assign rule_peak  = rt_rdata[2*VW-1:VW];
    assign rule_right = rt_rdata[VW-1:0];

    always_comb
    begin
        d_xa    = {sample_reg[VW-1], sample_reg} - {rule_left[VW-1], rule_left};
        d_ba    = {rule_peak[VW-1], rule_peak} - {rule_left[VW-1], rule_left};
        d_cx    = {rule_right[VW-1], rule_right} - {sample_reg[VW-1], sample_reg};
        d_cb    = {rule_right[VW-1], rule_right} - {rule_peak[VW-1], rule_peak};
        rise    = (sample_reg > rule_left) && (sample_reg < rule_peak);
        fall    = (sample_reg >= rule_peak) && (sample_reg < rule_right);
        mem_num = rise ? DW'(d_xa[VW-1:0]) : DW'(d_cx[VW-1:0]);
        mem_den = rise ? DW'(d_ba[VW-1:0]) : DW'(d_cb[VW-1:0]);
    end

    always_comb
    begin
        cfg_count = 32'(rules_in_use_reg);
        if (cfg_count == 32'd0)
        begin
            rule_count = 32'd1;
        end
        else if (cfg_count > 32'(MAX_RULES))
        begin
            rule_count = 32'(MAX_RULES);
        end
        else
        begin
            rule_count = cfg_count;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        last_idx_next     = last_idx_reg;
        sample_next       = sample_reg;
        sum_next          = sum_reg;
        rules_in_use_next = cfg_we ? cfg_wdata : rules_in_use_reg;
        out_valid_next    = out_valid_reg;
        rule_number_next  = rule_number_reg;
        weight_next       = weight_reg;
        last_next         = last_reg;
        dg_we             = 1'b0;
        dg_wdata          = '0;
        div_start         = 1'b0;
        div_num           = mem_num;
        div_den           = mem_den;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (func == FUNC_EVAL))
                begin
                    sample_next   = sample_value;
                    last_idx_next = IDX_W'(rule_count - 32'd1);
                    idx_next      = '0;
                    sum_next      = '0;
                    state_next    = S_RULE_RD;
                end
            end
            S_RULE_RD:
            begin
                state_next = S_RULE_SETUP;
            end
            S_RULE_SETUP:
            begin
                if (rise || fall)
                begin
                    div_start  = 1'b1;
                    state_next = S_RULE_DIV;
                end
                else
                begin
                    dg_we = 1'b1;
                    if (idx_reg == last_idx_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_NORM_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RULE_RD;
                    end
                end
            end
            S_RULE_DIV:
            begin
                if (div_done)
                begin
                    dg_we    = 1'b1;
                    dg_wdata = div_quot;
                    sum_next = sum_reg + SUM_W'(div_quot);
                    if (idx_reg == last_idx_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_NORM_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RULE_RD;
                    end
                end
            end
            S_NORM_RD:
            begin
                state_next = S_NORM_SETUP;
            end
            S_NORM_SETUP:
            begin
                rule_number_next = RULE_NUM_W'(idx_reg);
                last_next        = (idx_reg == last_idx_reg);
                if (sum_reg == '0)
                begin
                    weight_next    = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = DW'(dg_rdata);
                    div_den    = DW'(sum_reg);
                    state_next = S_NORM_DIV;
                end
            end
            S_NORM_DIV:
            begin
                if (div_done)
                begin
                    weight_next    = div_quot;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_NORM_RD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            last_idx_reg     <= '0;
            sample_reg       <= '0;
            sum_reg          <= '0;
            rules_in_use_reg <= CFG_RESET;
            out_valid_reg    <= 1'b0;
            rule_number_reg  <= '0;
            weight_reg       <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            last_idx_reg     <= last_idx_next;
            sample_reg       <= sample_next;
            sum_reg          <= sum_next;
            rules_in_use_reg <= rules_in_use_next;
            out_valid_reg    <= out_valid_next;
            rule_number_reg  <= rule_number_next;
            weight_reg       <= weight_next;
            last_reg         <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rule_number = rule_number_reg;
    assign weight      = weight_reg;
    assign last        = last_reg;

    ntm_ram #(
        .WIDTH (3 * VW),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (idx_reg),
        .rdata (rt_rdata)
    );

    ntm_ram #(
        .WIDTH (DEGREE_W),
        .DEPTH (MAX_RULES)
    ) u_degree_ram (
        .clk   (clk),
        .we    (dg_we),
        .waddr (idx_reg),
        .wdata (dg_wdata),
        .raddr (idx_reg),
        .rdata (dg_rdata)
    );

    ntm_div #(
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

endmodule
